### rtl/thermistor_adc_to_temperature_unit_assert.svh
// Assertion macros for the thermistor converter checker.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_UNIT_ASSERT_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TATU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TATU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tatu_pkg.sv
`default_nettype none
package tatu_pkg;

   localparam int BIAS_W        = 20;
   localparam int FS_W          = 10;
   localparam int DEN_W         = 17;
   localparam int MANT_W        = 32;
   localparam int FRAC_W        = 28;
   localparam int LN2_W         = 30;
   localparam int LN_SHIFT      = 34;
   localparam int LN_FRAC       = 24;
   localparam int COEF_W        = 64;
   localparam int HALF_W        = 32;
   localparam int TEMP_W        = 16;
   localparam int H_W           = 25;
   localparam int HMAG_W        = 24;
   localparam int DMAG_W        = 21;
   localparam int DIV10_SHIFT   = 27;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;

   localparam int HUNDRED          = 100;
   localparam int ABS_ZERO_HUND    = 45967;
   localparam int H_CAP            = 10000000;
   localparam int CLAMP_LO         = -4000;
   localparam int CLAMP_HI         = 35000;
   localparam int FALLBACK_COOLANT = 1800;
   localparam int FALLBACK_AIR     = 700;
   localparam int TEMP_MAX         = 32767;
   localparam int TEMP_MIN_MAG     = 32768;

   localparam logic [LN2_W-1:0]  LN2_Q30          = 30'd744261118;
   localparam logic [COEF_W-1:0] DIVIDEND_180_Q56 = 64'hB400_0000_0000_0000;
   localparam logic [HMAG_W-1:0] DIV10_RECIP      = 24'd13421773;

   localparam logic [BIAS_W-1:0] BIAS_RESET = 20'd2490;
   localparam logic [FS_W-1:0]   FS_RESET   = 10'd1023;

   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]      csr_data_type;
   typedef logic signed [TEMP_W-1:0]   temp_type;

   localparam csr_idx_type REG_COEF_A         = 3'd0;
   localparam csr_idx_type REG_COEF_B         = 3'd1;
   localparam csr_idx_type REG_COEF_C         = 3'd2;
   localparam csr_idx_type REG_BIAS_OHMS      = 3'd3;
   localparam csr_idx_type REG_FULL_SCALE     = 3'd4;
   localparam csr_idx_type REG_CLAMP_ENABLE   = 3'd5;
   localparam csr_idx_type REG_COOLANT_SENSOR = 3'd6;

endpackage
`default_nettype wire

### rtl/tatu_if.sv
`default_nettype none
interface tatu_req_if #(parameter int ADC_BITS = 10);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_count;
   modport source (output valid, output adc_count, input ready);
   modport sink   (input valid, input adc_count, output ready);
endinterface

interface tatu_rsp_if;
   logic               valid;
   logic               ready;
   tatu_pkg::temp_type temp_deci_f;
   logic               fallback_used;
   modport source (output valid, output temp_deci_f, output fallback_used, input ready);
   modport sink   (input valid, input temp_deci_f, input fallback_used, output ready);
endinterface

interface tatu_csr_if;
   logic                   valid;
   logic                   ready;
   tatu_pkg::csr_idx_type  index;
   tatu_pkg::csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/thermistor_adc_to_temperature_unit.sv
// Thermistor ADC count to temperature in tenths of a degree Fahrenheit.
// req_chan: one ADC count per beat (valid/ready). rsp_chan: one result
// beat per request, in order: temp_deci_f and fallback_used.
// csr_chan: register writes (index, data), always ready; write only while
// no request is in flight.
// Throughput: one request per clock while the receiver is ready; a stall
// holds the pipeline. The depth is set by the 28 mantissa squaring stages
// of the logarithm and the 64 restoring stages of the reciprocal divider,
// one bit per stage.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: coefficients 0, bias 2490, full scale 1023, clamp
// on, coolant sensor.
// When the receiver stalls, the whole pipeline holds; req_chan.ready
// follows (!rsp_chan.valid || rsp_chan.ready), so no beat is lost or
// repeated.
`default_nettype none
module thermistor_adc_to_temperature_unit #(
   parameter int ADC_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   tatu_req_if.sink   req_chan,
   tatu_rsp_if.source rsp_chan,
   tatu_csr_if.sink   csr_chan
);
   import tatu_pkg::*;

   localparam int CMP_W  = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;
   localparam int HUN_W  = ADC_BITS + 7;
   localparam int NUM_W  = BIAS_W + HUN_W;
   localparam int EXP_W  = $clog2(NUM_W);
   localparam int LOG_W  = EXP_W + FRAC_W;
   localparam int LN_W   = LOG_W + LN2_W - LN_SHIFT;
   localparam int L2_W   = 2 * LN_W - LN_FRAC;
   localparam int L3_W   = L2_W + LN_W - LN_FRAC;
   localparam int PB_W   = HALF_W + LN_W;
   localparam int PC_W   = HALF_W + L3_W;
   localparam int TB_W   = COEF_W + LN_W - LN_FRAC;
   localparam int TC_W   = COEF_W + L3_W - LN_FRAC;
   localparam int ACC_W  = TC_W + 2;
   localparam int SQ_STEPS  = FRAC_W;
   localparam int DIV_STEPS = COEF_W;

   typedef struct packed {
      logic [MANT_W-1:0] m;
      logic [FRAC_W-1:0] f;
      logic [EXP_W-1:0]  e;
   } lg_type;

   typedef struct packed {
      logic [COEF_W-1:0] rem;
      logic [COEF_W-1:0] quot;
      logic [COEF_W-1:0] dvs;
      logic              zero;
      logic              big;
   } dv_type;

   function automatic logic [EXP_W-1:0] msb_pos(input logic [NUM_W-1:0] x);
      logic [EXP_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (x[i]) begin
            pos = EXP_W'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [MANT_W-1:0] normalise(input logic [NUM_W-1:0] x,
                                                   input logic [EXP_W-1:0] e);
      logic [NUM_W+MANT_W-2:0] w;
      w = {x, {(MANT_W-1){1'b0}}} >> e;
      return w[MANT_W-1:0];
   endfunction

   function automatic lg_type sq_step(input lg_type a);
      logic [2*MANT_W-1:0] p;
      logic [MANT_W:0]     t;
      lg_type              r;
      p = (2*MANT_W)'(a.m) * (2*MANT_W)'(a.m);
      t = p[2*MANT_W-1:MANT_W-1];
      r.e = a.e;
      r.f = {a.f[FRAC_W-2:0], t[MANT_W]};
      r.m = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      return r;
   endfunction

   function automatic logic [LN_W-1:0] ln_of(input lg_type a);
      logic [LOG_W+LN2_W-1:0] p;
      p = (LOG_W+LN2_W)'({a.e, a.f}) * (LOG_W+LN2_W)'(LN2_Q30);
      return p[LOG_W+LN2_W-1:LN_SHIFT];
   endfunction

   function automatic dv_type div_step(input dv_type a, input logic b);
      logic [COEF_W:0] r2;
      logic [COEF_W:0] d2;
      dv_type          r;
      r  = a;
      r2 = {a.rem, b};
      d2 = r2 - {1'b0, a.dvs};
      if (r2 >= {1'b0, a.dvs}) begin
         r.rem  = d2[COEF_W-1:0];
         r.quot = {a.quot[COEF_W-2:0], 1'b1};
      end else begin
         r.rem  = r2[COEF_W-1:0];
         r.quot = {a.quot[COEF_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // configuration registers
   logic [COEF_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [BIAS_W-1:0] bias_ohms_ff;
   logic [FS_W-1:0]   full_scale_ff;
   logic              clamp_enable_ff, coolant_sensor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff         <= '0;
         coef_b_ff         <= '0;
         coef_c_ff         <= '0;
         bias_ohms_ff      <= BIAS_RESET;
         full_scale_ff     <= FS_RESET;
         clamp_enable_ff   <= 1'b1;
         coolant_sensor_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_COEF_A:         coef_a_ff         <= csr_chan.data;
            REG_COEF_B:         coef_b_ff         <= csr_chan.data;
            REG_COEF_C:         coef_c_ff         <= csr_chan.data;
            REG_BIAS_OHMS:      bias_ohms_ff      <= csr_chan.data[BIAS_W-1:0];
            REG_FULL_SCALE:     full_scale_ff     <= csr_chan.data[FS_W-1:0];
            REG_CLAMP_ENABLE:   clamp_enable_ff   <= csr_chan.data[0];
            REG_COOLANT_SENSOR: coolant_sensor_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   logic [COEF_W-1:0] cbm, ccm;
   assign cbm = coef_b_ff[COEF_W-1] ? (~coef_b_ff + COEF_W'(1)) : coef_b_ff;
   assign ccm = coef_c_ff[COEF_W-1] ? (~coef_c_ff + COEF_W'(1)) : coef_c_ff;

   // pipeline registers
   logic               rsp_valid_ff;
   logic               adv;

   logic               v1_ff, live1_ff;
   logic [NUM_W-1:0]   num1_ff;
   logic [DEN_W-1:0]   den1_ff;
   logic               live1_in;
   logic [HUN_W-1:0]   hun;
   logic [NUM_W-1:0]   num1_in;
   logic [DEN_W-1:0]   den1_in;

   logic               v2_ff, live2_ff;
   logic [NUM_W-1:0]   num2_ff, den2_ff;
   logic [EXP_W-1:0]   en2_ff, ed2_ff;

   logic               vsq_ff [0:SQ_STEPS];
   logic               livesq_ff [0:SQ_STEPS];
   lg_type             lgn_ff [0:SQ_STEPS];
   lg_type             lgd_ff [0:SQ_STEPS];
   lg_type             lgn_in [0:SQ_STEPS];
   lg_type             lgd_in [0:SQ_STEPS];

   logic               v4_ff, live4_ff;
   logic [LN_W-1:0]    lnn4_ff, lnd4_ff;

   logic               v5_ff, live5_ff, neg5_ff;
   logic [LN_W-1:0]    lm5_ff;

   logic               v6_ff, live6_ff, neg6_ff;
   logic [LN_W-1:0]    lm6_ff;
   logic [L2_W-1:0]    l2_6_ff;
   logic [PB_W-1:0]    pbl6_ff, pbh6_ff;
   logic [2*LN_W-1:0]  l2_prod;

   logic               v7_ff, live7_ff, neg7_ff;
   logic [L3_W-1:0]    l3_7_ff;
   logic [TB_W-1:0]    tb7_ff;
   logic [L2_W+LN_W-1:0]   l3_prod;
   logic [COEF_W+LN_W-1:0] pb_sum;

   logic               v8_ff, live8_ff, neg8_ff;
   logic [TB_W-1:0]    tb8_ff;
   logic [PC_W-1:0]    pcl8_ff, pch8_ff;

   logic               v9_ff, live9_ff, neg9_ff;
   logic [TB_W-1:0]    tb9_ff;
   logic [TC_W-1:0]    tc9_ff;
   logic [COEF_W+L3_W-1:0] pc_sum;

   logic               v10_ff, live10_ff;
   logic [ACC_W-1:0]   sb10_ff, sc10_ff;
   logic [ACC_W-1:0]   sb10_in, sc10_in;

   logic               v11_ff, live11_ff;
   logic [ACC_W-1:0]   acc11_ff;

   logic               vdv_ff [0:DIV_STEPS];
   dv_type             dv_ff [0:DIV_STEPS];
   dv_type             dv_in [0:DIV_STEPS];

   logic               vh_ff;
   logic signed [H_W-1:0] h_ff;
   logic signed [H_W-1:0] h_in;
   logic [COEF_W-1:0]  qq, qdif;

   logic               vm_ff, hneg_ff, oor_ff;
   logic [DMAG_W-1:0]  mag_ff;
   logic [HMAG_W-1:0]  habs;
   logic [2*HMAG_W-1:0] dprod;

   temp_type           temp_ff, temp_in, sat;
   logic               flag_ff, flag_in;

   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: divider ratio
   always_comb begin
      live1_in = (CMP_W'(req_chan.adc_count) < CMP_W'(full_scale_ff))
                 && (bias_ohms_ff != '0);
      hun      = HUN_W'(req_chan.adc_count) * HUN_W'(HUNDRED);
      if (req_chan.adc_count == '0) begin
         num1_in = NUM_W'(bias_ohms_ff);
         den1_in = DEN_W'(full_scale_ff) * DEN_W'(HUNDRED) - DEN_W'(1);
      end else begin
         num1_in = NUM_W'(bias_ohms_ff) * NUM_W'(hun);
         den1_in = (DEN_W'(full_scale_ff) - DEN_W'(req_chan.adc_count)) * DEN_W'(HUNDRED);
      end
   end

   // log2 mantissa squaring
   always_comb begin
      lgn_in[0].m = normalise(num2_ff, en2_ff);
      lgn_in[0].f = '0;
      lgn_in[0].e = en2_ff;
      lgd_in[0].m = normalise(den2_ff, ed2_ff);
      lgd_in[0].f = '0;
      lgd_in[0].e = ed2_ff;
      for (int k = 1; k <= SQ_STEPS; k++) begin
         lgn_in[k] = sq_step(lgn_ff[k-1]);
         lgd_in[k] = sq_step(lgd_ff[k-1]);
      end
   end

   assign l2_prod = (2*LN_W)'(lm5_ff) * (2*LN_W)'(lm5_ff);
   assign l3_prod = (L2_W+LN_W)'(l2_6_ff) * (L2_W+LN_W)'(lm6_ff);
   assign pb_sum  = {pbh6_ff, {HALF_W{1'b0}}} + (COEF_W+LN_W)'(pbl6_ff);
   assign pc_sum  = {pch8_ff, {HALF_W{1'b0}}} + (COEF_W+L3_W)'(pcl8_ff);

   always_comb begin
      sb10_in = (coef_b_ff[COEF_W-1] ^ neg9_ff) ? -ACC_W'(tb9_ff) : ACC_W'(tb9_ff);
      sc10_in = (coef_c_ff[COEF_W-1] ^ neg9_ff) ? -ACC_W'(tc9_ff) : ACC_W'(tc9_ff);
   end

   // reciprocal divider, one quotient bit a stage
   always_comb begin
      dv_in[0].rem  = '0;
      dv_in[0].quot = '0;
      dv_in[0].dvs  = acc11_ff[COEF_W-1:0];
      dv_in[0].zero = !live11_ff || acc11_ff[ACC_W-1] || (acc11_ff == '0);
      dv_in[0].big  = (acc11_ff[ACC_W-1:COEF_W] != '0);
      for (int j = 1; j <= DIV_STEPS; j++) begin
         dv_in[j] = div_step(dv_ff[j-1], DIVIDEND_180_Q56[DIV_STEPS-j]);
      end
   end

   // hundredths of a degree
   always_comb begin
      qq   = dv_ff[DIV_STEPS].big ? '0 : dv_ff[DIV_STEPS].quot;
      qdif = qq - COEF_W'(ABS_ZERO_HUND);
      if (dv_ff[DIV_STEPS].zero) begin
         h_in = -H_W'(ABS_ZERO_HUND);
      end else if (qq < COEF_W'(ABS_ZERO_HUND)) begin
         h_in = H_W'(qdif);
      end else if (qdif > COEF_W'(H_CAP)) begin
         h_in = H_W'(H_CAP);
      end else begin
         h_in = H_W'(qdif);
      end
   end

   assign habs  = h_ff[H_W-1] ? HMAG_W'(-h_ff) : HMAG_W'(h_ff);
   assign dprod = (2*HMAG_W)'(habs) * (2*HMAG_W)'(DIV10_RECIP);

   always_comb begin
      if (!hneg_ff) begin
         sat = (mag_ff > DMAG_W'(TEMP_MAX)) ? TEMP_W'(TEMP_MAX) : TEMP_W'(mag_ff);
      end else begin
         sat = (mag_ff > DMAG_W'(TEMP_MIN_MAG)) ? TEMP_W'(TEMP_MIN_MAG) : -TEMP_W'(mag_ff);
      end
      if (clamp_enable_ff && oor_ff) begin
         temp_in = coolant_sensor_ff ? TEMP_W'(FALLBACK_COOLANT) : TEMP_W'(FALLBACK_AIR);
         flag_in = 1'b1;
      end else begin
         temp_in = sat;
         flag_in = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int k = 0; k <= SQ_STEPS; k++) begin
            vsq_ff[k] <= 1'b0;
         end
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         for (int j = 0; j <= DIV_STEPS; j++) begin
            vdv_ff[j] <= 1'b0;
         end
         vh_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff     <= req_chan.valid;
         v2_ff     <= v1_ff;
         vsq_ff[0] <= v2_ff;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            vsq_ff[k] <= vsq_ff[k-1];
         end
         v4_ff     <= vsq_ff[SQ_STEPS];
         v5_ff     <= v4_ff;
         v6_ff     <= v5_ff;
         v7_ff     <= v6_ff;
         v8_ff     <= v7_ff;
         v9_ff     <= v8_ff;
         v10_ff    <= v9_ff;
         v11_ff    <= v10_ff;
         vdv_ff[0] <= v11_ff;
         for (int j = 1; j <= DIV_STEPS; j++) begin
            vdv_ff[j] <= vdv_ff[j-1];
         end
         vh_ff        <= vdv_ff[DIV_STEPS];
         vm_ff        <= vh_ff;
         rsp_valid_ff <= vm_ff;
      end
   end

   // payload; advance together, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         live1_ff <= live1_in;
         num1_ff  <= num1_in;
         den1_ff  <= den1_in;

         live2_ff <= live1_ff;
         num2_ff  <= num1_ff;
         den2_ff  <= NUM_W'(den1_ff);
         en2_ff   <= msb_pos(num1_ff);
         ed2_ff   <= msb_pos(NUM_W'(den1_ff));

         livesq_ff[0] <= live2_ff;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            livesq_ff[k] <= livesq_ff[k-1];
         end
         for (int k = 0; k <= SQ_STEPS; k++) begin
            lgn_ff[k] <= lgn_in[k];
            lgd_ff[k] <= lgd_in[k];
         end

         live4_ff <= livesq_ff[SQ_STEPS];
         lnn4_ff  <= ln_of(lgn_ff[SQ_STEPS]);
         lnd4_ff  <= ln_of(lgd_ff[SQ_STEPS]);

         live5_ff <= live4_ff;
         neg5_ff  <= lnn4_ff < lnd4_ff;
         lm5_ff   <= (lnn4_ff < lnd4_ff) ? (lnd4_ff - lnn4_ff) : (lnn4_ff - lnd4_ff);

         live6_ff <= live5_ff;
         neg6_ff  <= neg5_ff;
         lm6_ff   <= lm5_ff;
         l2_6_ff  <= l2_prod[2*LN_W-1:LN_FRAC];
         pbl6_ff  <= PB_W'(cbm[HALF_W-1:0]) * PB_W'(lm5_ff);
         pbh6_ff  <= PB_W'(cbm[COEF_W-1:HALF_W]) * PB_W'(lm5_ff);

         live7_ff <= live6_ff;
         neg7_ff  <= neg6_ff;
         l3_7_ff  <= l3_prod[L2_W+LN_W-1:LN_FRAC];
         tb7_ff   <= pb_sum[COEF_W+LN_W-1:LN_FRAC];

         live8_ff <= live7_ff;
         neg8_ff  <= neg7_ff;
         tb8_ff   <= tb7_ff;
         pcl8_ff  <= PC_W'(ccm[HALF_W-1:0]) * PC_W'(l3_7_ff);
         pch8_ff  <= PC_W'(ccm[COEF_W-1:HALF_W]) * PC_W'(l3_7_ff);

         live9_ff <= live8_ff;
         neg9_ff  <= neg8_ff;
         tb9_ff   <= tb8_ff;
         tc9_ff   <= pc_sum[COEF_W+L3_W-1:LN_FRAC];

         live10_ff <= live9_ff;
         sb10_ff   <= sb10_in;
         sc10_ff   <= sc10_in;

         live11_ff <= live10_ff;
         acc11_ff  <= {{(ACC_W-COEF_W){coef_a_ff[COEF_W-1]}}, coef_a_ff} + sb10_ff + sc10_ff;

         for (int j = 0; j <= DIV_STEPS; j++) begin
            dv_ff[j] <= dv_in[j];
         end

         h_ff <= h_in;

         hneg_ff <= h_ff[H_W-1];
         mag_ff  <= dprod[DIV10_SHIFT+DMAG_W-1:DIV10_SHIFT];
         oor_ff  <= (h_ff < H_W'(CLAMP_LO)) || (h_ff > H_W'(CLAMP_HI));

         temp_ff <= temp_in;
         flag_ff <= flag_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.temp_deci_f   = temp_ff;
   assign rsp_chan.fallback_used = flag_ff;

endmodule
`default_nettype wire

### rtl/tatu_checker.sv
`default_nettype none
`include "thermistor_adc_to_temperature_unit_assert.svh"
module tatu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input tatu_pkg::temp_type rsp_temp,
   input logic               rsp_fallback
);
   import tatu_pkg::*;

   `TATU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_temp) && $stable(rsp_fallback), "stalled result beat changed")
   `TATU_ASSERT_SAME(a_req_ready, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "request ready does not follow result side")
   `TATU_ASSERT_SAME(a_fallback_val, clock, reset, rsp_valid && rsp_fallback, rsp_temp == TEMP_W'(FALLBACK_COOLANT) || rsp_temp == TEMP_W'(FALLBACK_AIR), "fallback beat with wrong value")
   `TATU_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result beat right after reset")

endmodule

bind thermistor_adc_to_temperature_unit tatu_checker u_tatu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_temp     (rsp_chan.temp_deci_f),
   .rsp_fallback (rsp_chan.fallback_used)
);
`default_nettype wire

### verif/testbench.sv
`default_nettype none
class temperature_scoreboard;
   typedef struct packed {
      logic signed [15:0] temp_deci_f;
      logic               fallback_used;
   } reading_type;

   logic [63:0] coef_a, coef_b, coef_c;
   logic [19:0] bias_ohms;
   logic [9:0]  full_scale;
   bit          clamp_on, coolant;
   reading_type pending_readings[$];
   int          errors;

   function new();
      coef_a     = '0;
      coef_b     = '0;
      coef_c     = '0;
      bias_ohms  = tatu_pkg::BIAS_RESET;
      full_scale = tatu_pkg::FS_RESET;
      clamp_on   = 1'b1;
      coolant    = 1'b1;
      errors     = 0;
   endfunction

   function void write_reg(tatu_pkg::csr_idx_type idx, tatu_pkg::csr_data_type data);
      case (idx)
         tatu_pkg::REG_COEF_A:         coef_a = data;
         tatu_pkg::REG_COEF_B:         coef_b = data;
         tatu_pkg::REG_COEF_C:         coef_c = data;
         tatu_pkg::REG_BIAS_OHMS:      bias_ohms = data[19:0];
         tatu_pkg::REG_FULL_SCALE:     full_scale = data[9:0];
         tatu_pkg::REG_CLAMP_ENABLE:   clamp_on = data[0];
         tatu_pkg::REG_COOLANT_SENSOR: coolant = data[0];
         default: ;
      endcase
   endfunction

   // log2 in Q.28 by repeated squaring of the mantissa
   function logic [63:0] log2_fix(logic [63:0] x);
      int          e;
      logic [63:0] m, f;
      e = 63;
      while (e > 0 && !x[e]) e--;
      m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
      f = '0;
      for (int i = 0; i < 28; i++) begin
         m = (m * m) >> 31;
         f = f << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            f[0] = 1'b1;
         end
      end
      return (64'(e) << 28) | f;
   endfunction

   function logic [63:0] ln_fix(logic [63:0] x);
      return (log2_fix(x) * 64'd744261118) >> 34;
   endfunction

   // trunc(coef * (+-mag) / 2^24) as 128-bit two's complement
   function logic [127:0] scaled_term(logic [63:0] coef, logic [63:0] mag, bit neg);
      logic [63:0]  cm;
      logic [127:0] p;
      cm = coef[63] ? -coef : coef;
      p  = ({64'd0, cm} * {64'd0, mag}) >> 24;
      if (coef[63] != neg) p = -p;
      return p;
   endfunction

   function reading_type convert_count(logic [9:0] count);
      logic signed [63:0] h, deci;
      logic [63:0]        num, den, ln_n, ln_d, lm, l2, l3, q, d;
      logic [127:0]       acc;
      bit                 lneg;
      reading_type        r;
      h = -64'sd45967;
      if (count < full_scale && bias_ohms != 0) begin
         num  = (count == 0) ? 64'(bias_ohms) : 64'(bias_ohms) * 64'd100 * 64'(count);
         den  = (count == 0) ? 64'd100 * 64'(full_scale) - 64'd1
                             : 64'd100 * 64'(full_scale - count);
         ln_n = ln_fix(num);
         ln_d = ln_fix(den);
         lneg = ln_n < ln_d;
         lm   = lneg ? ln_d - ln_n : ln_n - ln_d;
         l2   = (lm * lm) >> 24;
         l3   = (l2 * lm) >> 24;
         acc  = {{64{coef_a[63]}}, coef_a} + scaled_term(coef_b, lm, lneg)
                + scaled_term(coef_c, l3, lneg);
         if (!acc[127] && acc != 0) begin
            q = (acc[127:64] != 0) ? 64'd0 : (64'd180 << 56) / acc[63:0];
            if (q >= 64'd45967) begin
               d = q - 64'd45967;
               if (d > 64'd10000000) d = 64'd10000000;
               h = $signed(d);
            end else begin
               h = -$signed(64'd45967 - q);
            end
         end
      end
      deci = h / 10;
      if (deci > 32767) deci = 32767;
      if (deci < -32768) deci = -32768;
      r.fallback_used = 1'b0;
      if (clamp_on && (h < -4000 || h > 35000)) begin
         deci = coolant ? 1800 : 700;
         r.fallback_used = 1'b1;
      end
      r.temp_deci_f = deci[15:0];
      return r;
   endfunction

   function void note_count(logic [9:0] count);
      pending_readings.push_back(convert_count(count));
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task check_reading(logic signed [15:0] temp, logic fallback);
      reading_type want;
      if (pending_readings.size() == 0) begin
         report($sformatf("unexpected beat temp %0d fallback %0b", temp, fallback));
      end else begin
         want = pending_readings.pop_front();
         if (temp !== want.temp_deci_f)
            report($sformatf("temp_deci_f %0d, want %0d", temp, want.temp_deci_f));
         if (fallback !== want.fallback_used)
            report($sformatf("fallback_used %0b, want %0b", fallback, want.fallback_used));
      end
   endtask
endclass

module testbench;
   import tatu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   cycles = 0;

   tatu_req_if #(.ADC_BITS(10)) req_chan();
   tatu_rsp_if                  rsp_chan();
   tatu_csr_if                  csr_chan();

   temperature_scoreboard readings = new();

   thermistor_adc_to_temperature_unit #(.ADC_BITS(10)) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.adc_count = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_COEF_A;
      csr_chan.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) readings.note_count(req_chan.adc_count);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         readings.check_reading(rsp_chan.temp_deci_f, rsp_chan.fallback_used);
      rsp_chan.ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 15);
   end

   task send_count(logic [9:0] count);
      if (!quiet) begin
         while ($urandom_range(99) < 15) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.adc_count <= count;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (readings.pending_readings.size() != 0) @(posedge clock);
   endtask

   task write_csr(csr_idx_type idx, csr_data_type data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      readings.write_reg(idx, data);
   endtask

   task set_config(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [19:0] bias,
                   logic [9:0] fs, bit clamp, bit cool);
      drain();
      write_csr(REG_COEF_A, a);
      write_csr(REG_COEF_B, b);
      write_csr(REG_COEF_C, c);
      write_csr(REG_BIAS_OHMS, {44'd0, bias});
      write_csr(REG_FULL_SCALE, {54'd0, fs});
      write_csr(REG_CLAMP_ENABLE, {63'd0, clamp});
      write_csr(REG_COOLANT_SENSOR, {63'd0, cool});
      csr_chan.valid <= 1'b0;
   endtask

   // mostly in range, with the edges around zero and full scale
   function logic [9:0] pick_count(logic [9:0] fs);
      case ($urandom_range(9))
         0: return 10'($urandom_range(2));
         1: return 10'(fs - 10'($urandom_range(2)));
         2: return 10'($urandom);
         default: return 10'($urandom_range(fs));
      endcase
   endfunction

   task random_phase(int n);
      for (int i = 0; i < n; i++) begin
         quiet = (i >= n / 3 && i < n / 3 + 40);
         send_count(pick_count(readings.full_scale));
         if (i == n / 2) drain();
      end
      quiet = 1'b0;
   endtask

   localparam logic [63:0] SH_A = 64'd79260000000000;
   localparam logic [63:0] SH_B = 64'd16570000000000;
   localparam logic [63:0] SH_C = 64'd6340000000;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_count(10'd0);
      send_count(10'd1023);
      send_count(10'd500);
      set_config(SH_A, SH_B, SH_C, 20'd2490, 10'd1023, 1'b1, 1'b1);
      send_count(10'd0);
      send_count(10'd1);
      send_count(10'd2);
      send_count(10'd100);
      send_count(10'd511);
      send_count(10'd512);
      send_count(10'd900);
      send_count(10'd1021);
      send_count(10'd1022);
      send_count(10'd1023);
      set_config(SH_A, SH_B, SH_C, 20'd2490, 10'd1023, 1'b1, 1'b0);
      send_count(10'd1023);
      send_count(10'd1022);
      set_config(SH_A, SH_B, SH_C, 20'd0, 10'd255, 1'b0, 1'b0);
      send_count(10'd10);
      set_config(SH_A, SH_B, SH_C, 20'hFFFFF, 10'd255, 1'b0, 1'b1);
      send_count(10'd0);
      send_count(10'd254);
      send_count(10'd255);
      send_count(10'd256);
      send_count(10'd1023);
      set_config(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF, 20'd1, 10'd1023, 1'b0, 1'b1);
      send_count(10'd1);
      send_count(10'd1022);
      send_count(10'd0);

      set_config(SH_A, SH_B, SH_C, 20'd2490, 10'd1023, 1'b1, 1'b1);
      random_phase(250);
      set_config(SH_A, SH_B, SH_C, 20'd2490, 10'd1023, 1'b0, 1'b0);
      random_phase(200);
      set_config(SH_A - 64'd2000000000000, SH_B + 64'd500000000000, SH_C, 20'($urandom),
                 10'($urandom_range(1023, 255)), 1'b1, 1'b0);
      random_phase(150);
      set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 20'($urandom), 10'($urandom_range(1023, 255)), 1'b1, 1'b1);
      random_phase(150);
      set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 20'($urandom), 10'($urandom_range(1023, 255)), 1'b0, 1'b0);
      random_phase(150);
      set_config(64'd1, 64'd0, 64'd0, 20'd10000, 10'd255, 1'b0, 1'b1);
      random_phase(100);
      set_config(SH_A, SH_B, SH_C, 20'hFFFFF, 10'd255, 1'b1, 1'b1);
      random_phase(150);
      set_config(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 20'd1, 10'd1023, 1'b0, 1'b0);
      random_phase(75);

      drain();
      repeat (120) @(posedge clock);
      if (readings.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
